/* src/sparse_matrix_row_store_unit_assert.svh */
// assertion macros for the sparse matrix row store
// used by the top level only, no other dependencies
`ifndef SPARSE_MATRIX_ROW_STORE_UNIT_ASSERT_SVH
`define SPARSE_MATRIX_ROW_STORE_UNIT_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define SMRS_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// consequent checked in the cycle after the antecedent
`define SMRS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/smrs_pkg.sv */
// shared types and constants of the sparse matrix row store
// no dependencies
package smrs_pkg;

   localparam int TYPE_W    = 2;
   localparam int ROW_W     = 5;
   localparam int COL_W     = 5;
   localparam int VAL_W     = 32;
   localparam int CSR_W     = 6;
   localparam int CSR_IDX_W = 1;

   localparam logic [CSR_W-1:0] CSR_ROWS_RESET = 6'd32;
   localparam logic [CSR_W-1:0] CSR_COLS_RESET = 6'd32;

   typedef enum logic [TYPE_W-1:0] {
      REQ_WRITE  = 2'd0,
      REQ_READ   = 2'd1,
      REQ_SEARCH = 2'd2,
      REQ_LIST   = 2'd3
   } req_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ROWS = 1'b0,
      CSR_COLS = 1'b1
   } csr_idx_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECODE,
      ST_RESULT,
      ST_SRCH_RUN,
      ST_SRCH_DRAIN,
      ST_LIST_LOAD,
      ST_LIST_SCAN,
      ST_LIST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic cap;
      logic rd_req;
      logic scan_step;
      logic list_load;
      logic list_rd;
      logic list_skip;
      logic emit_single;
      logic emit_entry;
      logic clr_step;
   } ctrl_cmd_type;

   typedef struct packed {
      req_kind_type kind;
      logic         clr_last;
      logic         row_ok;
      logic         scan_none;
      logic         scan_last;
      logic         list_none;
      logic         list_bit;
      logic         entry_last;
      logic         out_free;
   } dp_status_type;

endpackage

/* src/smrs_ifs.sv */
// request and response channel interfaces of the sparse matrix row store
// depends on smrs_pkg
interface smrs_req_if;
   import smrs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic [TYPE_W-1:0]       req_type;
   logic [ROW_W-1:0]        row_index;
   logic [COL_W-1:0]        col_index;
   logic signed [VAL_W-1:0] data_value;

   modport source (output valid, req_type, row_index, col_index, data_value, input ready);
   modport sink (input valid, req_type, row_index, col_index, data_value, output ready);
endinterface

interface smrs_rsp_if;
   import smrs_pkg::*;
   logic                    valid;
   logic                    ready;
   logic                    pos_error;
   logic                    found;
   logic [COL_W-1:0]        entry_col;
   logic signed [VAL_W-1:0] entry_value;
   logic                    row_empty;
   logic                    last;

   modport source (output valid, pos_error, found, entry_col, entry_value, row_empty, last,
                   input ready);
   modport sink (input valid, pos_error, found, entry_col, entry_value, row_empty, last,
                 output ready);
endinterface

/* src/smrs_ctrl.sv */
// sequencer of the sparse matrix row store
// depends on smrs_pkg, drives the datapath by command bits
module smrs_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output smrs_pkg::ctrl_cmd_type cmd,
   input  smrs_pkg::dp_status_type status
);
   import smrs_pkg::*;

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (status.clr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.cap  = 1'b1;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            cmd.rd_req = 1'b1;
            unique case (status.kind)
               REQ_WRITE, REQ_READ: state_in = ST_RESULT;
               REQ_LIST:            state_in = status.row_ok ? ST_LIST_LOAD : ST_RESULT;
               REQ_SEARCH:          state_in = status.scan_none ? ST_RESULT : ST_SRCH_RUN;
               default:             state_in = ST_RESULT;
            endcase
         end
         ST_SRCH_RUN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_last) begin
               state_in = ST_SRCH_DRAIN;
            end
         end
         ST_SRCH_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (status.out_free) begin
               cmd.emit_single = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         ST_LIST_LOAD: begin
            cmd.list_load = 1'b1;
            state_in      = status.list_none ? ST_RESULT : ST_LIST_SCAN;
         end
         ST_LIST_SCAN: begin
            if (status.list_bit) begin
               cmd.list_rd = 1'b1;
               state_in    = ST_LIST_EMIT;
            end else begin
               cmd.list_skip = 1'b1;
            end
         end
         ST_LIST_EMIT: begin
            if (status.out_free) begin
               cmd.emit_entry = 1'b1;
               state_in       = status.entry_last ? ST_IDLE : ST_LIST_SCAN;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

/* src/smrs_dpath.sv */
// datapath of the sparse matrix row store: registers, value and occupancy memories,
// scan counters and the result register; depends on smrs_pkg
module smrs_dpath #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [smrs_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [smrs_pkg::CSR_W-1:0]           csr_wdata,
   input  logic [smrs_pkg::TYPE_W-1:0]          in_req_type,
   input  logic [smrs_pkg::ROW_W-1:0]           in_row_index,
   input  logic [smrs_pkg::COL_W-1:0]           in_col_index,
   input  logic signed [smrs_pkg::VAL_W-1:0]    in_data_value,
   input  logic                                 out_ready,
   output logic                                 out_valid,
   output logic                                 out_pos_error,
   output logic                                 out_found,
   output logic [smrs_pkg::COL_W-1:0]           out_entry_col,
   output logic signed [smrs_pkg::VAL_W-1:0]    out_entry_value,
   output logic                                 out_row_empty,
   output logic                                 out_last,
   input  smrs_pkg::ctrl_cmd_type               cmd,
   output smrs_pkg::dp_status_type              status
);
   import smrs_pkg::*;

   localparam int ROW_AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int COL_AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int DEPTH  = MAX_ROWS * MAX_COLS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // rows and columns past the index width can never be addressed
   localparam int ROW_CAP = (MAX_ROWS < 2**ROW_W) ? MAX_ROWS : 2**ROW_W;
   localparam int COL_CAP = (MAX_COLS < 2**COL_W) ? MAX_COLS : 2**COL_W;

   // memories
   logic [VAL_W-1:0]    val_mem [DEPTH];
   logic [MAX_COLS-1:0] occ_mem [MAX_ROWS];

   // configuration
   logic [CSR_W-1:0] rows_ff, rows_in, cols_ff, cols_in;
   logic [CSR_W-1:0] nr, nc;

   // latched request
   req_kind_type     kind_ff, kind_in;
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;
   logic [VAL_W-1:0] key_ff, key_in;

   // clearing pass
   logic [ROW_AW-1:0] clr_cnt_ff, clr_cnt_in;

   // search scan
   logic [ROW_W-1:0] scan_r_ff, scan_r_in;
   logic [COL_W-1:0] scan_c_ff, scan_c_in, scan_cq_ff, scan_cq_in;
   logic             scan_v_ff, scan_v_in, hit_ff, hit_in;
   logic             scan_col_end, scan_match;

   // row listing
   logic [MAX_COLS-1:0] list_bits_ff, list_bits_in, col_mask, list_rest;
   logic [COL_W-1:0]    list_col_ff, list_col_in;

   // memory ports
   logic [MAX_COLS-1:0] occ_rd_ff, occ_wd, occ_upd;
   logic [VAL_W-1:0]    val_rd_ff;
   logic                rd_en, occ_we, val_we;
   logic [ROW_W-1:0]    rd_row;
   logic [COL_W-1:0]    rd_col;
   logic [ROW_AW-1:0]   occ_ra, occ_wa;
   logic [ADDR_W-1:0]   val_ra, val_wa;

   // status terms
   logic row_ok, pos_ok, key_nz, rd_hit;

   // result register
   logic             rv_ff, rv_in, perr_ff, perr_in, fnd_ff, fnd_in;
   logic             emp_ff, emp_in, lst_ff, lst_in;
   logic [COL_W-1:0] ecol_ff, ecol_in;
   logic [VAL_W-1:0] eval_ff, eval_in;

   // effective limits
   always_comb begin
      nr = (32'(rows_ff) < 32'(ROW_CAP)) ? rows_ff : CSR_W'(ROW_CAP);
      nc = (32'(cols_ff) < 32'(COL_CAP)) ? cols_ff : CSR_W'(COL_CAP);
      for (int i = 0; i < MAX_COLS; i++) begin
         col_mask[i] = (i < int'(nc));
      end
   end

   assign row_ok       = {1'b0, row_ff} < nr;
   assign pos_ok       = row_ok && ({1'b0, col_ff} < nc);
   assign key_nz       = key_ff != '0;
   assign rd_hit       = pos_ok && occ_rd_ff[COL_AW'(col_ff)];
   assign scan_col_end = ({1'b0, scan_c_ff} + 6'd1) == nc;
   assign scan_match   = scan_v_ff && occ_rd_ff[COL_AW'(scan_cq_ff)] && (val_rd_ff == key_ff);

   always_comb begin
      for (int i = 0; i < MAX_COLS; i++) begin
         list_rest[i] = list_bits_ff[i] && (i != int'(list_col_ff));
         occ_upd[i]   = (i == int'(col_ff)) ? key_nz : occ_rd_ff[i];
      end
   end

   // read address select
   always_comb begin
      priority if (cmd.scan_step) begin
         rd_row = scan_r_ff;
         rd_col = scan_c_ff;
      end else if (cmd.list_rd) begin
         rd_row = row_ff;
         rd_col = list_col_ff;
      end else begin
         rd_row = row_ff;
         rd_col = col_ff;
      end
   end

   assign rd_en  = cmd.rd_req | cmd.scan_step | cmd.list_rd;
   assign occ_ra = ROW_AW'(rd_row);
   assign val_ra = ADDR_W'(rd_row) * ADDR_W'(MAX_COLS) + ADDR_W'(rd_col);
   assign val_wa = ADDR_W'(row_ff) * ADDR_W'(MAX_COLS) + ADDR_W'(col_ff);

   // write port: clearing pass or a write request
   always_comb begin
      occ_we = 1'b0;
      occ_wa = ROW_AW'(row_ff);
      occ_wd = occ_upd;
      val_we = 1'b0;
      if (cmd.clr_step) begin
         occ_we = 1'b1;
         occ_wa = clr_cnt_ff;
         occ_wd = '0;
      end else if (cmd.emit_single && kind_ff == REQ_WRITE && pos_ok) begin
         occ_we = 1'b1;
         val_we = key_nz;
      end
   end

   always_ff @(posedge clock) begin
      if (occ_we) begin
         occ_mem[occ_wa] <= occ_wd;
      end
      if (rd_en) begin
         occ_rd_ff <= occ_mem[occ_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (val_we) begin
         val_mem[val_wa] <= key_ff;
      end
      if (rd_en) begin
         val_rd_ff <= val_mem[val_ra];
      end
   end

   // next values
   always_comb begin
      rows_in = rows_ff;
      cols_in = cols_ff;
      if (csr_we) begin
         if (csr_index == CSR_ROWS) begin
            rows_in = csr_wdata;
         end else begin
            cols_in = csr_wdata;
         end
      end

      kind_in = kind_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      key_in  = key_ff;
      if (cmd.cap) begin
         kind_in = req_kind_type'(in_req_type);
         row_in  = in_row_index;
         col_in  = in_col_index;
         key_in  = in_data_value;
      end

      clr_cnt_in = cmd.clr_step ? clr_cnt_ff + ROW_AW'(1) : clr_cnt_ff;

      scan_r_in  = scan_r_ff;
      scan_c_in  = scan_c_ff;
      scan_v_in  = cmd.scan_step;
      scan_cq_in = scan_c_ff;
      hit_in     = hit_ff | scan_match;
      if (cmd.cap) begin
         scan_r_in = '0;
         scan_c_in = '0;
         hit_in    = 1'b0;
      end else if (cmd.scan_step) begin
         if (scan_col_end) begin
            scan_c_in = '0;
            scan_r_in = scan_r_ff + ROW_W'(1);
         end else begin
            scan_c_in = scan_c_ff + COL_W'(1);
         end
      end

      list_bits_in = list_bits_ff;
      list_col_in  = list_col_ff;
      if (cmd.list_load) begin
         list_bits_in = occ_rd_ff & col_mask;
         list_col_in  = '0;
      end else if (cmd.emit_entry) begin
         list_bits_in = list_rest;
         list_col_in  = list_col_ff + COL_W'(1);
      end else if (cmd.list_skip) begin
         list_col_in = list_col_ff + COL_W'(1);
      end

      rv_in   = rv_ff & ~out_ready;
      perr_in = perr_ff;
      fnd_in  = fnd_ff;
      ecol_in = ecol_ff;
      eval_in = eval_ff;
      emp_in  = emp_ff;
      lst_in  = lst_ff;
      if (cmd.emit_single) begin
         rv_in   = 1'b1;
         fnd_in  = 1'b0;
         ecol_in = '0;
         eval_in = '0;
         emp_in  = 1'b0;
         lst_in  = 1'b1;
         unique case (kind_ff)
            REQ_WRITE: begin
               perr_in = !pos_ok;
            end
            REQ_READ: begin
               perr_in = !pos_ok;
               eval_in = rd_hit ? val_rd_ff : '0;
            end
            REQ_SEARCH: begin
               perr_in = 1'b0;
               fnd_in  = hit_ff;
            end
            REQ_LIST: begin
               perr_in = !row_ok;
               emp_in  = row_ok;
            end
            default: begin
               perr_in = 1'b0;
            end
         endcase
      end else if (cmd.emit_entry) begin
         rv_in   = 1'b1;
         perr_in = 1'b0;
         fnd_in  = 1'b0;
         ecol_in = list_col_ff;
         eval_in = val_rd_ff;
         emp_in  = 1'b0;
         lst_in  = (list_rest == '0);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff    <= CSR_ROWS_RESET;
         cols_ff    <= CSR_COLS_RESET;
         clr_cnt_ff <= '0;
         scan_v_ff  <= 1'b0;
         rv_ff      <= 1'b0;
      end else begin
         rows_ff    <= rows_in;
         cols_ff    <= cols_in;
         clr_cnt_ff <= clr_cnt_in;
         scan_v_ff  <= scan_v_in;
         rv_ff      <= rv_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      key_ff       <= key_in;
      scan_r_ff    <= scan_r_in;
      scan_c_ff    <= scan_c_in;
      scan_cq_ff   <= scan_cq_in;
      hit_ff       <= hit_in;
      list_bits_ff <= list_bits_in;
      list_col_ff  <= list_col_in;
      perr_ff      <= perr_in;
      fnd_ff       <= fnd_in;
      ecol_ff      <= ecol_in;
      eval_ff      <= eval_in;
      emp_ff       <= emp_in;
      lst_ff       <= lst_in;
   end

   always_comb begin
      status.kind       = kind_ff;
      status.clr_last   = clr_cnt_ff == ROW_AW'(MAX_ROWS - 1);
      status.row_ok     = row_ok;
      status.scan_none  = !key_nz || nr == '0 || nc == '0;
      status.scan_last  = scan_col_end && (({1'b0, scan_r_ff} + 6'd1) == nr);
      status.list_none  = (occ_rd_ff & col_mask) == '0;
      status.list_bit   = list_bits_ff[COL_AW'(list_col_ff)];
      status.entry_last = list_rest == '0;
      status.out_free   = !rv_ff || out_ready;
   end

   assign out_valid       = rv_ff;
   assign out_pos_error   = perr_ff;
   assign out_found       = fnd_ff;
   assign out_entry_col   = ecol_ff;
   assign out_entry_value = eval_ff;
   assign out_row_empty   = emp_ff;
   assign out_last        = lst_ff;

endmodule

/* src/sparse_matrix_row_store_unit.sv */
// sparse matrix row store: holds a sparse 32-bit integer matrix as per-row column occupancy
// plus a value memory. a write stores a value (zero removes the entry), a read returns the
// stored value or 0, a search reports whether a value is held anywhere in the rows and
// columns in use, and a row listing returns one word per stored entry in ascending column
// order with last on the final one (an empty row gives one word with row_empty set).
// positions outside rows_in_use / cols_in_use are flagged with pos_error and change nothing.
// timing: after reset the occupancy memory is swept clear, one row per cycle, over all
// MAX_ROWS rows; no request is taken during the sweep, csr writes are. one request is worked
// at a time by the sequencer over a single read port on each memory. a search compares one
// stored word per cycle across the rows and columns in use (none for a zero key or an empty
// window); a listing steps through the row's columns one at a time, up to its last entry.
// the result register lets a new request be accepted while the previous word waits.
// depends on smrs_pkg, smrs_ifs, smrs_ctrl, smrs_dpath and the assertion macro header
module sparse_matrix_row_store_unit #(
   parameter int MAX_ROWS = 32,
   parameter int MAX_COLS = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   smrs_req_if.sink                       req_chan,
   smrs_rsp_if.source                     rsp_chan,
   input  logic                           csr_we,
   input  logic [smrs_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [smrs_pkg::CSR_W-1:0]     csr_wdata
);
   import smrs_pkg::*;

   `include "sparse_matrix_row_store_unit_assert.svh"

   ctrl_cmd_type  cmd;
   dp_status_type status;
   logic          req_ready;

   // sequencer
   smrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .cmd       (cmd),
      .status    (status)
   );

   assign req_chan.ready = req_ready;

   // memories, counters and result register
   smrs_dpath #(
      .MAX_ROWS (MAX_ROWS),
      .MAX_COLS (MAX_COLS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .in_req_type     (req_chan.req_type),
      .in_row_index    (req_chan.row_index),
      .in_col_index    (req_chan.col_index),
      .in_data_value   (req_chan.data_value),
      .out_ready       (rsp_chan.ready),
      .out_valid       (rsp_chan.valid),
      .out_pos_error   (rsp_chan.pos_error),
      .out_found       (rsp_chan.found),
      .out_entry_col   (rsp_chan.entry_col),
      .out_entry_value (rsp_chan.entry_value),
      .out_row_empty   (rsp_chan.row_empty),
      .out_last        (rsp_chan.last),
      .cmd             (cmd),
      .status          (status)
   );

   // no response word can come out while the occupancy sweep runs
   `SMRS_ASSERT_NOW(a_quiet_in_clear, clock, reset, cmd.clr_step, !rsp_chan.valid, "word during clear")

   // a word without last only comes from a listing, and never as an error or empty marker
   `SMRS_ASSERT_NOW(a_partial_is_list, clock, reset, rsp_chan.valid && !rsp_chan.last, status.kind == REQ_LIST && !rsp_chan.pos_error && !rsp_chan.row_empty, "bad partial word")

   // found only answers a search, as a single clean word
   `SMRS_ASSERT_NOW(a_found_search, clock, reset, rsp_chan.valid && rsp_chan.found, rsp_chan.last && !rsp_chan.pos_error && !rsp_chan.row_empty, "found outside search")

   // the block opens for requests right after the sweep ends
   `SMRS_ASSERT_NEXT(a_ready_after_clear, clock, reset, cmd.clr_step && status.clr_last, req_chan.ready, "not ready after clear")

endmodule

/* tb/sv/sparse_matrix_row_store_unit_test.sv */
// self-checking testbench for the sparse matrix row store: directed and random requests,
// every result word checked against a predictor kept in the testbench
// depends on smrs_pkg, smrs_ifs and sparse_matrix_row_store_unit
module sparse_matrix_row_store_unit_test;
   timeunit 1ns;
   timeprecision 1ps;

   import smrs_pkg::*;

   localparam int MAX_ROWS = 32;
   localparam int MAX_COLS = 32;
   localparam int IDLE_PCT = 37;
   localparam int POOL_SIZE = 8;

   // one result word as the checker sees it
   typedef struct packed {
      logic              pos_error;
      logic              found;
      logic [COL_W-1:0]  entry_col;
      logic [VAL_W-1:0]  entry_value;
      logic              row_empty;
      logic              last;
   } rsp_word_type;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]   csr_wdata;

   smrs_req_if req_chan ();
   smrs_rsp_if rsp_chan ();

   sparse_matrix_row_store_unit #(
      .MAX_ROWS(MAX_ROWS),
      .MAX_COLS(MAX_COLS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // matrix image kept by the predictor
   logic [VAL_W-1:0]    stored_value [MAX_ROWS][MAX_COLS];
   logic [MAX_COLS-1:0] occupied [MAX_ROWS];
   logic [CSR_W-1:0]    rows_limit;
   logic [CSR_W-1:0]    cols_limit;

   // result words still owed by the block, oldest first
   rsp_word_type pending_words[$];

   int  error_count = 0;
   bit  idle_on = 1'b1;        // random idling on both channels
   bit  req_offered = 1'b0;    // valid is currently being driven high
   int  hold_request = 0;      // long receiver hold-off, picked up by the receiver

   // recently written nonzero values, so that searches and reads hit
   logic [VAL_W-1:0] recent_values [POOL_SIZE] = '{32'h1, 32'h2, 32'h3, 32'hFF,
                                                   32'h100, 32'hDEAD_BEEF, 32'h7, 32'h9};
   int recent_slot = 0;

   // 8 ns clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit, far above the slowest legal run
   initial begin : watchdog
      #16ms;
      $display("DONE: errors detected");
      $finish;
   end

   // ------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------

   // a register value above the matrix size acts as the full size
   function automatic int effective(logic [CSR_W-1:0] lim, int cap);
      return (int'(lim) > cap) ? cap : int'(lim);
   endfunction

   function automatic rsp_word_type make_word(logic perr, logic fnd, logic [COL_W-1:0] col,
                                              logic [VAL_W-1:0] val, logic empty, logic lst);
      rsp_word_type w;
      w.pos_error   = perr;
      w.found       = fnd;
      w.entry_col   = col;
      w.entry_value = val;
      w.row_empty   = empty;
      w.last        = lst;
      return w;
   endfunction

   // updates the matrix image and queues the words one accepted request produces
   function automatic void predict_request(req_kind_type kind, logic [ROW_W-1:0] row,
                                           logic [COL_W-1:0] col, logic [VAL_W-1:0] val);
      int  nr;
      int  nc;
      bit  row_ok;
      bit  pos_ok;
      bit  hit;
      int  last_col;
      logic [VAL_W-1:0] rd;
      nr     = effective(rows_limit, MAX_ROWS);
      nc     = effective(cols_limit, MAX_COLS);
      row_ok = int'(row) < nr;
      pos_ok = row_ok && (int'(col) < nc);
      case (kind)
         REQ_WRITE: begin
            // zero removes, anything else is stored, negatives included
            if (pos_ok) begin
               if (val != '0) begin
                  stored_value[row][col] = val;
                  occupied[row][col] = 1'b1;
               end else begin
                  occupied[row][col] = 1'b0;
               end
            end
            pending_words.push_back(make_word(!pos_ok, 1'b0, '0, '0, 1'b0, 1'b1));
         end
         REQ_READ: begin
            rd = '0;
            if (pos_ok && occupied[row][col]) rd = stored_value[row][col];
            pending_words.push_back(make_word(!pos_ok, 1'b0, '0, rd, 1'b0, 1'b1));
         end
         REQ_SEARCH: begin
            // only the window in use counts; zero is never stored
            hit = 1'b0;
            if (val != '0) begin
               for (int r = 0; r < nr; r++) begin
                  for (int c = 0; c < nc; c++) begin
                     if (occupied[r][c] && stored_value[r][c] == val) hit = 1'b1;
                  end
               end
            end
            pending_words.push_back(make_word(1'b0, hit, '0, '0, 1'b0, 1'b1));
         end
         default: begin
            // row listing, column index ignored
            if (!row_ok) begin
               pending_words.push_back(make_word(1'b1, 1'b0, '0, '0, 1'b0, 1'b1));
            end else begin
               last_col = -1;
               for (int c = 0; c < nc; c++) begin
                  if (occupied[row][c]) last_col = c;
               end
               if (last_col < 0) begin
                  pending_words.push_back(make_word(1'b0, 1'b0, '0, '0, 1'b1, 1'b1));
               end else begin
                  for (int c = 0; c <= last_col; c++) begin
                     if (occupied[row][c]) begin
                        pending_words.push_back(make_word(1'b0, 1'b0, COL_W'(c),
                                                          stored_value[row][c], 1'b0,
                                                          c == last_col));
                     end
                  end
               end
            end
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // result side
   // ------------------------------------------------------------------

   function automatic void check_field(string name, logic [VAL_W-1:0] want,
                                       logic [VAL_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         error_count++;
      end
   endfunction

   // ready with random idling and an occasional long hold-off counted here
   initial begin : result_receiver
      int hold_left;
      hold_left = 0;
      rsp_chan.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_chan.ready <= 1'b0;
            hold_left--;
         end else begin
            rsp_chan.ready <= !(idle_on && $urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // every accepted word against the oldest one owed
   initial begin : result_checker
      rsp_word_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_chan.valid && rsp_chan.ready) begin
            if (pending_words.size() == 0) begin
               $error("result word with nothing pending: col %0d value %0h last %0b",
                      rsp_chan.entry_col, rsp_chan.entry_value, rsp_chan.last);
               error_count++;
            end else begin
               want = pending_words.pop_front();
               check_field("pos_error", want.pos_error, rsp_chan.pos_error);
               check_field("found", want.found, rsp_chan.found);
               check_field("entry_col", want.entry_col, rsp_chan.entry_col);
               check_field("entry_value", want.entry_value, rsp_chan.entry_value);
               check_field("row_empty", want.row_empty, rsp_chan.row_empty);
               check_field("last", want.last, rsp_chan.last);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------

   // offers one request word, returns at the edge it is taken
   task automatic send_request(req_kind_type kind, logic [ROW_W-1:0] row,
                               logic [COL_W-1:0] col, logic [VAL_W-1:0] val);
      while (idle_on && $urandom_range(99) < IDLE_PCT) begin
         if (req_offered) begin
            req_chan.valid <= 1'b0;
            req_offered = 1'b0;
         end
         @(posedge clock);
      end
      req_chan.valid      <= 1'b1;
      req_offered          = 1'b1;
      req_chan.req_type   <= kind;
      req_chan.row_index  <= row;
      req_chan.col_index  <= col;
      req_chan.data_value <= val;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      predict_request(kind, row, col, val);
   endtask

   // stop offering and wait until every owed word is back
   task automatic drain_results();
      if (req_offered) begin
         req_chan.valid <= 1'b0;
         req_offered = 1'b0;
      end
      while (pending_words.size() != 0) @(posedge clock);
   endtask

   // register writes only while the block is idle
   task automatic set_limits(logic [CSR_W-1:0] rows, logic [CSR_W-1:0] cols);
      drain_results();
      csr_we    <= 1'b1;
      csr_index <= CSR_ROWS;
      csr_wdata <= rows;
      @(posedge clock);
      rows_limit = rows;
      csr_index <= CSR_COLS;
      csr_wdata <= cols;
      @(posedge clock);
      cols_limit = cols;
      csr_we <= 1'b0;
   endtask

   // mostly inside the window in use, sometimes anywhere
   function automatic logic [4:0] pick_index(int lim);
      if (lim > 0 && $urandom_range(99) < 80) return 5'($urandom_range(lim - 1));
      return 5'($urandom_range(31));
   endfunction

   function automatic logic [VAL_W-1:0] pick_value();
      int r;
      r = $urandom_range(99);
      if (r < 12) return '0;
      if (r < 22) begin
         case ($urandom_range(3))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
         endcase
      end
      if (r < 55) return recent_values[$urandom_range(POOL_SIZE - 1)];
      return $urandom;
   endfunction

   task automatic send_random_request();
      int               pick;
      req_kind_type     kind;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
      logic [VAL_W-1:0] val;
      pick = $urandom_range(99);
      if (pick < 40)      kind = REQ_WRITE;
      else if (pick < 65) kind = REQ_READ;
      else if (pick < 80) kind = REQ_SEARCH;
      else                kind = REQ_LIST;
      row = pick_index(effective(rows_limit, MAX_ROWS));
      col = pick_index(effective(cols_limit, MAX_COLS));
      val = pick_value();
      if (kind == REQ_WRITE && val != '0) begin
         recent_values[recent_slot] = val;
         recent_slot = (recent_slot + 1) % POOL_SIZE;
      end
      send_request(kind, row, col, val);
   endtask

   // ------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------

   // corners of the matrix, extreme values, removal by zero
   task automatic test_basic_access();
      send_request(REQ_READ, 5'd0, 5'd0, 32'h0);              // nothing stored yet
      send_request(REQ_WRITE, 5'd0, 5'd0, 32'h7FFF_FFFF);
      send_request(REQ_WRITE, 5'd31, 5'd31, 32'h8000_0000);   // negative is kept
      send_request(REQ_WRITE, 5'd0, 5'd31, 32'hFFFF_FFFF);
      send_request(REQ_WRITE, 5'd5, 5'd7, 32'h1234_5678);
      send_request(REQ_READ, 5'd0, 5'd0, 32'hFFFF_FFFF);
      send_request(REQ_READ, 5'd31, 5'd31, 32'h0);
      send_request(REQ_WRITE, 5'd5, 5'd7, 32'h0);             // zero removes
      send_request(REQ_READ, 5'd5, 5'd7, 32'h0);
      send_request(REQ_WRITE, 5'd9, 5'd9, 32'h0);             // removing an empty slot
   endtask

   // multi-entry row, empty row, single entry in the last row
   task automatic test_row_listing();
      send_request(REQ_LIST, 5'd0, 5'd31, 32'h0);
      send_request(REQ_LIST, 5'd5, 5'd0, 32'h0);
      send_request(REQ_LIST, 5'd31, 5'd17, 32'hFFFF_FFFF);
   endtask

   task automatic test_search();
      send_request(REQ_SEARCH, 5'd31, 5'd31, 32'h8000_0000);
      send_request(REQ_SEARCH, 5'd0, 5'd0, 32'h0);            // zero never matches
   endtask

   // shrunk window hides entries, zero window flags everything, then they come back
   task automatic test_limits();
      set_limits(6'd1, 6'd1);
      send_request(REQ_WRITE, 5'd1, 5'd0, 32'h5);
      send_request(REQ_READ, 5'd0, 5'd1, 32'h0);
      send_request(REQ_LIST, 5'd1, 5'd0, 32'h0);
      send_request(REQ_LIST, 5'd0, 5'd0, 32'h0);
      send_request(REQ_SEARCH, 5'd0, 5'd0, 32'hFFFF_FFFF);    // held at col 31, hidden
      send_request(REQ_SEARCH, 5'd0, 5'd0, 32'h7FFF_FFFF);
      set_limits(6'd0, 6'd32);
      send_request(REQ_WRITE, 5'd0, 5'd0, 32'h3);
      send_request(REQ_LIST, 5'd0, 5'd0, 32'h0);
      send_request(REQ_SEARCH, 5'd0, 5'd0, 32'h7FFF_FFFF);
      set_limits(6'd63, 6'd63);                               // above the matrix size
      send_request(REQ_LIST, 5'd0, 5'd0, 32'h0);
   endtask

   // random traffic over a range of window sizes, small ones favored
   task automatic test_random_traffic();
      logic [CSR_W-1:0] phase_rows [8] = '{6'd32, 6'd4, 6'd1, 6'd32, 6'd7, 6'd63, 6'd2, 6'd32};
      logic [CSR_W-1:0] phase_cols [8] = '{6'd32, 6'd4, 6'd32, 6'd1, 6'd13, 6'd40, 6'd3, 6'd0};
      for (int p = 0; p < 8; p++) begin
         set_limits(phase_rows[p], phase_cols[p]);
         repeat (32) send_random_request();
      end
   endtask

   // back-to-back words on both channels
   task automatic test_no_idle_stretch();
      set_limits(6'd16, 6'd16);
      idle_on = 1'b0;
      repeat (30) send_random_request();
      drain_results();
      idle_on = 1'b1;
   endtask

   // receiver holds off while requests keep coming, so the input stalls
   task automatic test_backpressure();
      set_limits(6'd8, 6'd8);
      hold_request = 300;
      repeat (24) send_random_request();
   endtask

   initial begin
      reset                = 1'b1;
      csr_we               = 1'b0;
      csr_index            = CSR_ROWS;
      csr_wdata            = '0;
      req_chan.valid       = 1'b0;
      req_chan.req_type    = REQ_WRITE;
      req_chan.row_index   = '0;
      req_chan.col_index   = '0;
      req_chan.data_value  = '0;
      rows_limit           = CSR_ROWS_RESET;
      cols_limit           = CSR_COLS_RESET;
      for (int r = 0; r < MAX_ROWS; r++) begin
         occupied[r] = '0;
         for (int c = 0; c < MAX_COLS; c++) stored_value[r][c] = '0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // the clearing sweep after reset holds ready low, send waits it out
      test_basic_access();
      test_row_listing();
      test_search();
      test_limits();
      test_random_traffic();
      test_no_idle_stretch();
      test_backpressure();

      drain_results();
      // room for any stray word past the last one owed
      repeat (64) @(posedge clock);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
